// ----- src/dtt_pkg.sv -----
// Shared types, constants and helpers for the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;

    localparam int SLOTS   = 16;
    localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT = 16;
    localparam int NW      = $clog2(MAX_OUT + 1);
    localparam int QDEPTH  = 2;
    localparam int QPW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_CANCEL  = 3'd1;
    localparam logic [2:0] MODE_REFRESH = 3'd2;
    localparam logic [2:0] MODE_RESET   = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;
    localparam logic [2:0] MODE_EXPIRE  = 3'd5;

    typedef enum logic [2:0] {
        OP_ADD, OP_CANCEL, OP_REFRESH, OP_RESET, OP_QUERY, OP_EXPIRE, OP_BAD
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RDWAIT, ST_RSTWR, ST_SCAN, ST_FIN
    } t_state;

    typedef struct packed {
        t_op            op;
        logic [63:0]    now;
        logic [IW-1:0]  idx;
        logic           id_ok;
        logic [31:0]    per;
        logic           rep;
        logic           fnow;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  slot;
        logic        ok;
        logic        front;
        logic [63:0] ttn;
        logic        fired;
        logic        last;
    } t_res;

    function automatic logic [3:0] out_slot(input logic [IW-1:0] s);
        logic [IW+3:0] t;
        t = {4'd0, s};
        return t[3:0];
    endfunction

    function automatic t_res mk_res(input logic [3:0] slot, input logic ok,
                                    input logic front, input logic [63:0] ttn,
                                    input logic fired, input logic last);
        t_res r;
        r.slot  = slot;
        r.ok    = ok;
        r.front = front;
        r.ttn   = ttn;
        r.fired = fired;
        r.last  = last;
        return r;
    endfunction

endpackage

// ----- src/dtt_front.sv -----
// Command front end: decodes each transaction and holds it in a short queue.
`timescale 1ns / 1ps
module dtt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  logic [2:0]    i_mode,
    input  logic [63:0]   i_now_ms,
    input  logic [3:0]    i_slot_id,
    input  logic [31:0]   i_period_ms,
    input  logic          i_repeat_req,
    input  logic          i_from_now,
    output logic          o_q_valid,
    output dtt_pkg::t_cmd o_q_data,
    input  logic          i_q_pop
);
    import dtt_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [QPW-1:0]   r_rd, r_wr;
    logic [QCW-1:0]   r_cnt;
    t_cmd             cmd;
    logic             push, pop;

    always_comb begin
        case (i_mode)
            MODE_ADD:     cmd.op = OP_ADD;
            MODE_CANCEL:  cmd.op = OP_CANCEL;
            MODE_REFRESH: cmd.op = OP_REFRESH;
            MODE_RESET:   cmd.op = OP_RESET;
            MODE_QUERY:   cmd.op = OP_QUERY;
            MODE_EXPIRE:  cmd.op = OP_EXPIRE;
            default:      cmd.op = OP_BAD;
        endcase
        cmd.now   = i_now_ms;
        cmd.idx   = IW'(i_slot_id);
        cmd.id_ok = {28'd0, i_slot_id} < 32'(SLOTS);
        cmd.per   = i_period_ms;
        cmd.rep   = i_repeat_req;
        cmd.fnow  = i_from_now;
    end

    assign o_busy    = (r_cnt == QCW'(QDEPTH));
    assign push      = i_start && !o_busy;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/dtt_back.sv -----
// Command back end: slot table, scan sequencer and result register.
`timescale 1ns / 1ps
module dtt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dtt_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_valid,
    output dtt_pkg::t_res o_res
);
    import dtt_pkg::*;

    logic [63:0] mem_dl  [SLOTS];
    logic [31:0] mem_per [SLOTS];
    logic [63:0] rd_dl;
    logic [31:0] rd_per;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [SLOTS-1:0] r_active, n_active, r_repeat, n_repeat, r_due, n_due;
    logic            r_announced, n_announced;
    logic [IW-1:0]   r_cnt, n_cnt, r_rd_idx, n_rd_idx, r_tgt, n_tgt;
    logic [IW-1:0]   r_best_idx, n_best_idx;
    logic            r_issue, n_issue, r_rd_vld, n_rd_vld;
    logic            r_first, n_first, r_any, n_any, r_pass1, n_pass1;
    logic [63:0]     r_best_dl, n_best_dl, r_tgt_dl, n_tgt_dl;
    logic [31:0]     r_best_per, n_best_per;
    logic [NW-1:0]   r_nout, n_nout;
    logic            r_valid, n_valid;
    t_res            r_res, n_res;

    logic [IW-1:0]   rd_addr, wa;
    logic            we_dl, we_per;
    logic [63:0]     wdl;
    logic [31:0]     wper;
    logic            free_any;
    logic [IW-1:0]   free_idx;
    logic            cand, front;
    logic [SLOTS-1:0] due_after;
    logic            last;

    always_ff @(posedge i_clk) begin
        if (we_dl) begin
            mem_dl[wa] <= wdl;
        end
        if (we_per) begin
            mem_per[wa] <= wper;
        end
        rd_dl  <= mem_dl[rd_addr];
        rd_per <= mem_per[rd_addr];
    end

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_active    = r_active;
        n_repeat    = r_repeat;
        n_due       = r_due;
        n_announced = r_announced;
        n_cnt       = r_cnt;
        n_rd_idx    = r_cnt;
        n_tgt       = r_tgt;
        n_best_idx  = r_best_idx;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_first     = r_first;
        n_any       = r_any;
        n_pass1     = r_pass1;
        n_best_dl   = r_best_dl;
        n_tgt_dl    = r_tgt_dl;
        n_best_per  = r_best_per;
        n_nout      = r_nout;
        n_valid     = 1'b0;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        rd_addr     = r_cnt;
        wa          = r_cmd.idx;
        we_dl       = 1'b0;
        we_per      = 1'b0;
        wdl         = '0;
        wper        = '0;
        cand        = 1'b0;
        front       = 1'b0;
        due_after   = r_due;
        last        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                rd_addr = i_q_data.idx;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    // scan setup, used by the ops that sweep the table
                    n_cnt   = '0;
                    n_issue = 1'b1;
                    n_any   = 1'b0;
                    n_first = 1'b1;
                    case (i_q_data.op)
                        OP_ADD: begin
                            if (!free_any) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                            end else begin
                                wa                 = free_idx;
                                we_dl              = 1'b1;
                                we_per             = 1'b1;
                                wdl                = i_q_data.now + 64'(i_q_data.per);
                                wper               = i_q_data.per;
                                n_active[free_idx] = 1'b1;
                                n_repeat[free_idx] = i_q_data.rep;
                                n_tgt              = free_idx;
                                n_tgt_dl           = wdl;
                                n_state            = ST_SCAN;
                            end
                        end
                        OP_CANCEL: begin
                            n_valid = 1'b1;
                            n_res   = mk_res(4'd0,
                                i_q_data.id_ok && r_active[i_q_data.idx],
                                1'b0, '0, 1'b0, 1'b1);
                            if (i_q_data.id_ok) begin
                                n_active[i_q_data.idx] = 1'b0;
                            end
                        end
                        OP_REFRESH, OP_RESET: begin
                            if (!i_q_data.id_ok) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                            end else begin
                                n_state = ST_RDWAIT;
                            end
                        end
                        OP_QUERY: begin
                            n_announced = 1'b0;
                            n_state     = ST_SCAN;
                        end
                        OP_EXPIRE: begin
                            n_due   = '0;
                            n_nout  = '0;
                            n_pass1 = 1'b1;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_res   = mk_res(4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end

            ST_RDWAIT: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_res   = mk_res(4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                if (r_cmd.op == OP_REFRESH) begin
                    if (r_active[r_cmd.idx]) begin
                        we_dl    = 1'b1;
                        wdl      = r_cmd.now + 64'(rd_per);
                        n_res.ok = 1'b1;
                    end
                end else if (r_cmd.per == rd_per && !r_cmd.fnow) begin
                    n_res.ok = 1'b1;
                end else if (r_active[r_cmd.idx]) begin
                    n_valid  = 1'b0;
                    n_tgt    = r_cmd.idx;
                    n_tgt_dl = r_cmd.fnow ? r_cmd.now : rd_dl - 64'(rd_per);
                    n_state  = ST_RSTWR;
                end
            end

            ST_RSTWR: begin
                we_dl    = 1'b1;
                we_per   = 1'b1;
                wdl      = r_tgt_dl + 64'(r_cmd.per);
                wper     = r_cmd.per;
                n_tgt_dl = wdl;
                n_state  = ST_SCAN;
            end

            ST_SCAN: begin
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt;
                    if (r_cnt == IW'(SLOTS - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    case (r_cmd.op)
                        OP_ADD, OP_RESET: begin
                            if (r_rd_idx != r_tgt && r_active[r_rd_idx] &&
                                (rd_dl < r_tgt_dl ||
                                 (rd_dl == r_tgt_dl && r_rd_idx < r_tgt))) begin
                                n_first = 1'b0;
                            end
                        end
                        OP_QUERY: cand = r_active[r_rd_idx];
                        OP_EXPIRE: begin
                            if (r_pass1) begin
                                cand = r_active[r_rd_idx] && rd_dl <= r_cmd.now;
                                n_due[r_rd_idx] = cand;
                            end else begin
                                cand = r_due[r_rd_idx];
                            end
                        end
                        default: cand = 1'b0;
                    endcase
                    // ascending index order: strict compare keeps the lower index on ties
                    if (cand && (!r_any || rd_dl < r_best_dl)) begin
                        n_any      = 1'b1;
                        n_best_idx = r_rd_idx;
                        n_best_dl  = rd_dl;
                        n_best_per = rd_per;
                    end
                    if (r_rd_idx == IW'(SLOTS - 1)) begin
                        n_state = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                case (r_cmd.op)
                    OP_ADD, OP_RESET: begin
                        front = r_first && !r_announced;
                        if (front) begin
                            n_announced = 1'b1;
                        end
                        n_res = mk_res((r_cmd.op == OP_ADD) ? out_slot(r_tgt) : 4'd0,
                                       1'b1, front, '0, 1'b0, 1'b1);
                    end
                    OP_QUERY: begin
                        n_res = mk_res(4'd0, 1'b1, 1'b0,
                            !r_any ? '1 :
                            (r_best_dl <= r_cmd.now) ? 64'd0 : r_best_dl - r_cmd.now,
                            1'b0, 1'b1);
                    end
                    default: begin
                        if (!r_any) begin
                            // only reached with nothing due at all
                            n_res = mk_res(4'd0, 1'b1, 1'b0, '0, 1'b0, 1'b1);
                        end else begin
                            wa = r_best_idx;
                            if (r_repeat[r_best_idx]) begin
                                we_dl = 1'b1;
                                wdl   = r_cmd.now + 64'(r_best_per);
                            end else begin
                                n_active[r_best_idx] = 1'b0;
                            end
                            due_after[r_best_idx] = 1'b0;
                            n_due   = due_after;
                            last    = (due_after == '0) || (r_nout == NW'(MAX_OUT - 1));
                            n_res   = mk_res(out_slot(r_best_idx), 1'b1, 1'b0, '0,
                                             1'b1, last);
                            n_nout  = r_nout + 1'b1;
                            n_pass1 = 1'b0;
                            if (!last) begin
                                n_cnt   = '0;
                                n_issue = 1'b1;
                                n_any   = 1'b0;
                                n_state = ST_SCAN;
                            end
                        end
                    end
                endcase
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_repeat   <= n_repeat;
        r_due      <= n_due;
        r_cnt      <= n_cnt;
        r_rd_idx   <= n_rd_idx;
        r_tgt      <= n_tgt;
        r_best_idx <= n_best_idx;
        r_first    <= n_first;
        r_any      <= n_any;
        r_pass1    <= n_pass1;
        r_best_dl  <= n_best_dl;
        r_tgt_dl   <= n_tgt_dl;
        r_best_per <= n_best_per;
        r_nout     <= n_nout;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_announced <= 1'b0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_announced <= n_announced;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_valid     <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- src/deadline_timer_table_core.sv -----
// Top level of the deadline timer table: front queue plus execution back end.
`timescale 1ns / 1ps
// A table of 16 timer slots driven by command transactions. A transaction is
// taken when i_start is high and o_busy is low; a two-entry queue holds
// commands while the back end works, so o_busy rises only when it is full.
// Every result appears for exactly one cycle with o_valid high and cannot be
// held off; o_last marks the final result of a transaction. Timing per
// transaction is set by the back end's slot memory, which has a registered
// read and is swept one slot per cycle. An idle back end takes a queued
// command in the cycle right after it is accepted. Cancel, unused modes and
// out-of-range slots are answered from the idle state; refresh, and a reset
// that ends early (unchanged period or inactive slot), after one slot read;
// add and query after a sweep of the table; a reset that moves a deadline
// after a slot write and a sweep; expire after a sweep for its first
// result (also when nothing is due) and a new sweep per further fired slot.
module deadline_timer_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_now_ms,
    input  logic [3:0]  i_slot_id,
    input  logic [31:0] i_period_ms,
    input  logic        i_repeat_req,
    input  logic        i_from_now,
    output logic        o_valid,
    output logic [3:0]  o_result_slot,
    output logic        o_ok,
    output logic        o_new_earliest,
    output logic [63:0] o_time_to_next,
    output logic        o_fired,
    output logic        o_last
);
    import dtt_pkg::*;

    logic q_valid, q_pop;
    t_cmd q_data;
    t_res res;

    // decode and buffer incoming transactions
    dtt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_now_ms     (i_now_ms),
        .i_slot_id    (i_slot_id),
        .i_period_ms  (i_period_ms),
        .i_repeat_req (i_repeat_req),
        .i_from_now   (i_from_now),
        .o_q_valid    (q_valid),
        .o_q_data     (q_data),
        .i_q_pop      (q_pop)
    );

    // execute against the slot table
    dtt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_res     (res)
    );

    assign o_result_slot  = res.slot;
    assign o_ok           = res.ok;
    assign o_new_earliest = res.front;
    assign o_time_to_next = res.ttn;
    assign o_fired        = res.fired;
    assign o_last         = res.last;

endmodule
